/* hdl/boundary_tag_allocator_core_defines.svh */
// assertion macros for the boundary tag allocator
// used by the top level, expects i_clk and i_rst_n in scope
`ifndef BOUNDARY_TAG_ALLOCATOR_CORE_DEFINES_SVH
`define BOUNDARY_TAG_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define BTA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bta: same-cycle check failed");

// next-cycle implication
`define BTA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bta: next-cycle check failed");

`endif

/* hdl/bta_pkg.sv */
// shared types, op codes and helpers of the boundary tag allocator
// no dependencies
`timescale 1ns / 1ps

package bta_pkg;

    localparam int TYPE_W = 2;
    localparam int REQ_W  = 14;
    localparam int ADDR_W = 12;
    localparam int NEED_W = REQ_W - 1;

    localparam logic [TYPE_W-1:0] REQ_ALLOC  = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_FREE   = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_RESIZE = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;

    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_INIT0     = 5'd0;
    localparam logic [OP_W-1:0] OP_INIT1     = 5'd1;
    localparam logic [OP_W-1:0] OP_IDLE      = 5'd2;
    localparam logic [OP_W-1:0] OP_AW_RD     = 5'd3;
    localparam logic [OP_W-1:0] OP_AW_CHK    = 5'd4;
    localparam logic [OP_W-1:0] OP_W0        = 5'd5;
    localparam logic [OP_W-1:0] OP_W1        = 5'd6;
    localparam logic [OP_W-1:0] OP_W2        = 5'd7;
    localparam logic [OP_W-1:0] OP_W3        = 5'd8;
    localparam logic [OP_W-1:0] OP_FR_RD0    = 5'd9;
    localparam logic [OP_W-1:0] OP_FR_C0     = 5'd10;
    localparam logic [OP_W-1:0] OP_FR_RD1    = 5'd11;
    localparam logic [OP_W-1:0] OP_FR_C1     = 5'd12;
    localparam logic [OP_W-1:0] OP_FR_RD2    = 5'd13;
    localparam logic [OP_W-1:0] OP_FR_C2     = 5'd14;
    localparam logic [OP_W-1:0] OP_FR_W0     = 5'd15;
    localparam logic [OP_W-1:0] OP_FR_W1     = 5'd16;
    localparam logic [OP_W-1:0] OP_VW_RD     = 5'd17;
    localparam logic [OP_W-1:0] OP_VW_C      = 5'd18;
    localparam logic [OP_W-1:0] OP_VW_END    = 5'd19;
    localparam logic [OP_W-1:0] OP_VW_H      = 5'd20;
    localparam logic [OP_W-1:0] OP_GR_RD     = 5'd21;
    localparam logic [OP_W-1:0] OP_GR_C      = 5'd22;
    localparam logic [OP_W-1:0] OP_DONE_OK   = 5'd23;
    localparam logic [OP_W-1:0] OP_DONE_FAIL = 5'd24;
    localparam logic [OP_W-1:0] OP_DONE_FREE = 5'd25;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            load;
        logic            split;
    } t_cmd;

    typedef struct packed {
        logic [TYPE_W-1:0] in_type;
        logic              in_addr_nz;
        logic              cur_lt_n;
        logic              cur_lt_h;
        logic              fit;
        logic              rd_zero;
        logic              rd_free;
        logic              frnx_lt_n;
        logic              fp_nz;
        logic              vw_match;
        logic              need_lt;
        logic              need_eq;
        logic              grnx_lt_n;
        logic              grow_ok;
        logic              out_free;
    } t_stat;

    // block size in words: payload plus header and footer, rounded to 8 bytes
    function automatic logic [NEED_W-1:0] need_words(input logic [REQ_W-1:0] req);
        logic [REQ_W:0] sum;
        sum = {1'b0, req} + (REQ_W+1)'(15);
        return {sum[REQ_W:3], 1'b0};
    endfunction

endpackage

/* hdl/bta_if.sv */
// request and response channels of the boundary tag allocator
// depends on bta_pkg
`timescale 1ns / 1ps

interface bta_req_if import bta_pkg::*;;
    logic              valid;
    logic              ready;
    logic [TYPE_W-1:0] req_type;
    logic [REQ_W-1:0]  request_bytes;
    logic [ADDR_W-1:0] block_address;

    modport source (output valid, req_type, request_bytes, block_address, input ready);
    modport sink   (input valid, req_type, request_bytes, block_address, output ready);
endinterface

interface bta_rsp_if import bta_pkg::*;;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] result_address;
    logic              status;

    modport source (output valid, result_address, status, input ready);
    modport sink   (input valid, result_address, status, output ready);
endinterface

/* hdl/bta_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module bta_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/bta_ctl.sv */
// sequencer of the boundary tag allocator: walks, splits and merges
// depends on bta_pkg
`timescale 1ns / 1ps

module bta_ctl import bta_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [1:0] POST_NONE  = 2'd0;
    localparam logic [1:0] POST_MOVE  = 2'd1;
    localparam logic [1:0] POST_SPLIT = 2'd2;
    localparam logic [1:0] POST_FREE  = 2'd3;

    logic [OP_W-1:0] r_state, n_state;
    logic [1:0]      r_post, n_post;
    logic            load;

    assign o_in_ready  = (r_state == OP_IDLE);
    assign load        = o_in_ready && i_in_valid;
    assign o_cmd.op    = r_state;
    assign o_cmd.load  = load;
    assign o_cmd.split = (r_post == POST_SPLIT);

    always_comb begin
        n_state = r_state;
        n_post  = r_post;
        unique case (r_state)
            OP_INIT0: n_state = OP_INIT1;
            OP_INIT1: n_state = OP_IDLE;
            OP_IDLE: begin
                if (load) begin
                    if (i_stat.in_type == REQ_ALLOC) begin
                        n_post  = POST_NONE;
                        n_state = OP_AW_RD;
                    end else if ((i_stat.in_type == REQ_FREE ||
                                  i_stat.in_type == REQ_RESIZE) && i_stat.in_addr_nz) begin
                        n_post  = (i_stat.in_type == REQ_FREE) ? POST_FREE : POST_NONE;
                        n_state = OP_VW_RD;
                    end else begin
                        n_state = OP_DONE_FAIL;
                    end
                end
            end
            OP_AW_RD:  n_state = i_stat.cur_lt_n ? OP_AW_CHK : OP_DONE_FAIL;
            OP_AW_CHK: begin
                priority if (i_stat.fit)  n_state = OP_W0;
                else if (i_stat.rd_zero)  n_state = OP_DONE_FAIL;
                else                      n_state = OP_AW_RD;
            end
            OP_W0: n_state = OP_W1;
            OP_W1: n_state = OP_W2;
            OP_W2: n_state = OP_W3;
            OP_W3: n_state = (r_post == POST_NONE) ? OP_DONE_OK : OP_FR_RD0;
            OP_FR_RD0: n_state = OP_FR_C0;
            OP_FR_C0:  n_state = OP_FR_RD1;
            OP_FR_RD1: n_state = i_stat.frnx_lt_n ? OP_FR_C1 : OP_FR_RD2;
            OP_FR_C1:  n_state = OP_FR_RD2;
            OP_FR_RD2: n_state = i_stat.fp_nz ? OP_FR_C2 : OP_FR_W0;
            OP_FR_C2:  n_state = OP_FR_W0;
            OP_FR_W0:  n_state = OP_FR_W1;
            OP_FR_W1:  n_state = (r_post == POST_FREE) ? OP_DONE_FREE : OP_DONE_OK;
            OP_VW_RD:  n_state = (i_stat.cur_lt_n && i_stat.cur_lt_h) ? OP_VW_C : OP_VW_END;
            OP_VW_C:   n_state = i_stat.rd_zero ? OP_DONE_FAIL : OP_VW_RD;
            OP_VW_END: n_state = i_stat.vw_match ? OP_VW_H : OP_DONE_FAIL;
            OP_VW_H: begin
                priority if (i_stat.rd_free)   n_state = OP_DONE_FAIL;
                else if (r_post == POST_FREE)  n_state = OP_FR_RD0;
                else if (i_stat.need_lt) begin
                    n_post  = POST_SPLIT;
                    n_state = OP_W0;
                end else if (i_stat.need_eq)   n_state = OP_DONE_OK;
                else                           n_state = OP_GR_RD;
            end
            OP_GR_RD: begin
                if (i_stat.grnx_lt_n) begin
                    n_state = OP_GR_C;
                end else begin
                    n_post  = POST_MOVE;
                    n_state = OP_AW_RD;
                end
            end
            OP_GR_C: begin
                if (i_stat.grow_ok) begin
                    n_state = OP_W0;
                end else begin
                    n_post  = POST_MOVE;
                    n_state = OP_AW_RD;
                end
            end
            OP_DONE_OK, OP_DONE_FAIL, OP_DONE_FREE: begin
                if (i_stat.out_free) n_state = OP_IDLE;
            end
            default: n_state = OP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= OP_INIT0;
            r_post  <= POST_NONE;
        end else begin
            r_state <= n_state;
            r_post  <= n_post;
        end
    end

endmodule

/* hdl/bta_dp.sv */
// datapath of the boundary tag allocator: pointers, sizes, tag ram, result register
// depends on bta_pkg and bta_ram
`timescale 1ns / 1ps

module bta_dp import bta_pkg::*; #(
    parameter int STORE_WORDS = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic [TYPE_W-1:0] i_req_type,
    input  logic [REQ_W-1:0]  i_request_bytes,
    input  logic [ADDR_W-1:0] i_block_address,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [ADDR_W-1:0] o_result_address,
    output logic              o_status
);

    localparam int AW = $clog2(STORE_WORDS);
    localparam int TW = AW + 3;
    localparam int DW = ((AW + 1 > NEED_W) ? AW + 1 : NEED_W) + 1;
    localparam logic [DW-1:0] N_DW = DW'(STORE_WORDS);
    localparam logic [DW-1:0] ONE  = DW'(1);

    logic [DW-1:0] r_cur, r_h, r_sz, r_need, r_tot, r_fh, r_fp;
    logic [ADDR_W-1:0] r_res, r_ores;
    logic r_ovalid, r_ost;

    logic          ram_we, ram_re;
    logic [DW-1:0] wa_full, ra_full;
    logic [TW-1:0] ram_wdata, ram_rdata;
    logic [DW-1:0] rd_sz;
    logic          rd_a, split_rem, out_free, done;

    // tag: size in bytes with the allocated flag in bit 0
    function automatic logic [TW-1:0] mk_tag(input logic [DW-1:0] words, input logic alloc);
        return {words[AW:0], 1'b0, alloc};
    endfunction

    assign rd_sz     = DW'(ram_rdata[TW-1:2]);
    assign rd_a      = ram_rdata[0];
    assign split_rem = (r_tot > r_need);
    assign out_free  = !r_ovalid || i_out_ready;
    assign done      = out_free && (i_cmd.op == OP_DONE_OK || i_cmd.op == OP_DONE_FAIL ||
                                    i_cmd.op == OP_DONE_FREE);

    assign o_stat.in_type    = i_req_type;
    assign o_stat.in_addr_nz = (i_block_address != '0);
    assign o_stat.cur_lt_n   = (r_cur < N_DW);
    assign o_stat.cur_lt_h   = (r_cur < r_h);
    assign o_stat.fit        = !rd_a && (rd_sz >= r_need);
    assign o_stat.rd_zero    = (rd_sz == '0);
    assign o_stat.rd_free    = !rd_a;
    assign o_stat.frnx_lt_n  = ((r_fp + r_tot) < N_DW);
    assign o_stat.fp_nz      = (r_fp != '0);
    assign o_stat.vw_match   = (r_cur == r_h) && (r_h < N_DW);
    assign o_stat.need_lt    = (r_need < rd_sz);
    assign o_stat.need_eq    = (r_need == rd_sz);
    assign o_stat.grnx_lt_n  = ((r_h + r_sz) < N_DW);
    assign o_stat.grow_ok    = !rd_a && (r_need <= (r_sz + rd_sz));
    assign o_stat.out_free   = out_free;

    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        wa_full   = '0;
        ra_full   = '0;
        ram_wdata = '0;
        unique case (i_cmd.op)
            OP_INIT0: begin
                ram_we    = 1'b1;
                ram_wdata = mk_tag(N_DW, 1'b0);
            end
            OP_INIT1: begin
                ram_we    = 1'b1;
                wa_full   = N_DW - ONE;
                ram_wdata = mk_tag(N_DW, 1'b0);
            end
            OP_AW_RD: begin
                ram_re  = o_stat.cur_lt_n;
                ra_full = r_cur;
            end
            OP_VW_RD: begin
                ram_re  = o_stat.cur_lt_n && o_stat.cur_lt_h;
                ra_full = r_cur;
            end
            // remainder of a split, only when the block is larger than needed
            OP_W0: begin
                ram_we    = split_rem;
                wa_full   = r_fh + r_need;
                ram_wdata = mk_tag(r_tot - r_need, 1'b0);
            end
            OP_W1: begin
                ram_we    = split_rem;
                wa_full   = r_fh + r_tot - ONE;
                ram_wdata = mk_tag(r_tot - r_need, 1'b0);
            end
            OP_W2: begin
                ram_we    = 1'b1;
                wa_full   = r_fh;
                ram_wdata = mk_tag(r_need, 1'b1);
            end
            OP_W3: begin
                ram_we    = 1'b1;
                wa_full   = r_fh + r_need - ONE;
                ram_wdata = mk_tag(r_need, 1'b1);
            end
            OP_FR_RD0: begin
                ram_re  = 1'b1;
                ra_full = r_fp;
            end
            OP_FR_RD1: begin
                ram_re  = o_stat.frnx_lt_n;
                ra_full = r_fp + r_tot;
            end
            OP_FR_RD2: begin
                ram_re  = o_stat.fp_nz;
                ra_full = r_fp - ONE;
            end
            OP_FR_W0: begin
                ram_we    = 1'b1;
                wa_full   = r_fp;
                ram_wdata = mk_tag(r_tot, 1'b0);
            end
            OP_FR_W1: begin
                ram_we    = 1'b1;
                wa_full   = r_fp + r_tot - ONE;
                ram_wdata = mk_tag(r_tot, 1'b0);
            end
            OP_VW_END: begin
                ram_re  = o_stat.vw_match;
                ra_full = r_h;
            end
            OP_GR_RD: begin
                ram_re  = o_stat.grnx_lt_n;
                ra_full = r_h + r_sz;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_IDLE: begin
                if (i_cmd.load) begin
                    r_cur  <= '0;
                    r_need <= DW'(need_words(i_request_bytes));
                    r_h    <= DW'(i_block_address) - ONE;
                    r_res  <= '0;
                end
            end
            OP_AW_CHK: begin
                r_fh  <= r_cur;
                r_tot <= rd_sz;
                r_cur <= r_cur + rd_sz;
            end
            OP_W3: begin
                r_res <= ADDR_W'(r_fh + ONE);
                if (i_cmd.split) r_fp <= r_fh + r_need;
            end
            OP_FR_C0: r_tot <= rd_sz;
            OP_FR_C1: begin
                if (!rd_a) r_tot <= r_tot + rd_sz;
            end
            OP_FR_C2: begin
                if (!rd_a) begin
                    r_fp  <= r_fp - rd_sz;
                    r_tot <= r_tot + rd_sz;
                end
            end
            OP_VW_C: r_cur <= r_cur + rd_sz;
            OP_VW_H: begin
                r_sz  <= rd_sz;
                r_tot <= rd_sz;
                r_fh  <= r_h;
                r_fp  <= r_h;
                r_res <= ADDR_W'(r_h + ONE);
            end
            OP_GR_RD: r_cur <= '0;
            OP_GR_C: begin
                r_cur <= '0;
                r_tot <= r_sz + rd_sz;
            end
            default: begin
                r_cur <= r_cur;
            end
        endcase
        if (done) begin
            r_ores <= (i_cmd.op == OP_DONE_OK) ? r_res : '0;
            r_ost  <= (i_cmd.op == OP_DONE_FAIL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (done) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_result_address = r_ores;
    assign o_status         = r_ost;

    bta_ram #(
        .WIDTH (TW),
        .DEPTH (STORE_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wa_full[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ra_full[AW-1:0]),
        .o_rdata (ram_rdata)
    );

endmodule

/* hdl/boundary_tag_allocator_core.sv */
// top level of the boundary tag first-fit allocator
// depends on bta_pkg, bta_if, bta_ctl, bta_dp, bta_ram and the defines header
//
// channel   dir  handshake      payload
// i_req     in   valid/ready    req_type, request_bytes, block_address
// o_rsp     out  valid/ready    result_address, status
//
// allocate: a read and a check per header walked, then states W0 to W3 and the post
// free: a read and a check per block walked ahead of the address, VW_END, VW_H,
//   then the merge reads, checks and writes and a post state
// resize: address walk, then split (+free), keep, grow in place, or allocate and free
// each walk step is a tag ram read and a check state, so fragmentation sets the rate
// after reset INIT0 and INIT1 write the first header and footer before any item
// the result waits in an output register; a new item is taken while it stalls
`timescale 1ns / 1ps
`include "boundary_tag_allocator_core_defines.svh"

module boundary_tag_allocator_core import bta_pkg::*; #(
    parameter int STORE_WORDS = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bta_req_if.sink   i_req,
    bta_rsp_if.source o_rsp
);

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    assign i_req.ready = in_ready;

    bta_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bta_dp #(
        .STORE_WORDS (STORE_WORDS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_req_type       (i_req.req_type),
        .i_request_bytes  (i_req.request_bytes),
        .i_block_address  (i_req.block_address),
        .i_out_ready      (o_rsp.ready),
        .o_out_valid      (o_rsp.valid),
        .o_result_address (o_rsp.result_address),
        .o_status         (o_rsp.status)
    );

    `BTA_ASSERT_NXT(a_busy_after_accept, i_req.valid && i_req.ready, !i_req.ready)
    `BTA_ASSERT_IMP(a_fail_has_no_address, o_rsp.valid && o_rsp.status, o_rsp.result_address == '0)
    `BTA_ASSERT_IMP(a_result_follows_work, $rose(o_rsp.valid), $past(!i_req.ready))

endmodule
